// ===== rtl/iptfs_payload_block_parser_defines.svh =====
// assertion macros for the iptfs payload block parser
// used by the modules that carry concurrent checks
`ifndef IPTFS_PAYLOAD_BLOCK_PARSER_DEFINES_SVH
`define IPTFS_PAYLOAD_BLOCK_PARSER_DEFINES_SVH

// implication checked on every clock edge out of reset
`define IPBP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// implication checked even during reset
`define IPBP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ipbp_pkg.sv =====
// shared types and constants for the iptfs payload block parser
// no dependencies
package ipbp_pkg;

    localparam int LenW = 16;

    typedef enum logic [3:0] {
        EV_HEADER   = 4'd0,
        EV_REJECT   = 4'd1,
        EV_CONT     = 4'd2,
        EV_IPV4     = 4'd3,
        EV_IPV6     = 4'd4,
        EV_IPV4_FRAG = 4'd5,
        EV_IPV6_FRAG = 4'd6,
        EV_PAD      = 4'd7,
        EV_UNKNOWN  = 4'd8
    } ev_kind_t;

    // one result transfer
    typedef struct packed {
        logic        all_pad;
        logic [31:0] rx_seq;
        logic [31:0] loss_rate;
        logic [15:0] delay;
        logic [15:0] rtt;
        logic [15:0] offset;
        logic        cc_present;
        logic [15:0] blen;
        logic [15:0] bstart;
        ev_kind_t    kind;
    } ev_t;

    localparam int EvW = $bits(ev_t);

endpackage

// ===== rtl/ipbp_front.sv =====
// front end: per-byte parse state machine, classifies bytes into events
// depends on ipbp_pkg and iptfs_payload_block_parser_defines.svh
module ipbp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              first_byte,
    input  logic [15:0]       payload_length,
    output logic              ev_valid,
    output ipbp_pkg::ev_t     ev_data,
    input  logic              ev_ready
);
    import ipbp_pkg::*;
`include "iptfs_payload_block_parser_defines.svh"

    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_AFTER_HDR, PH_BLOCK_FIRST, PH_BLOCK_HEAD, PH_SKIP
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [15:0]  pos_reg, pos_next;
    logic [15:0]  total_reg, total_next;
    logic [127:0] hdr_reg, hdr_next;
    logic         cc_reg, cc_next;
    logic [15:0]  cur_start_reg, cur_start_next;
    logic         cur_v6_reg, cur_v6_next;
    logic [7:0]   len_hi_reg, len_hi_next;
    logic [15:0]  skip_reg, skip_next;

    logic         emit;
    ev_t          ev;
    logic         take;
    logic [7:0]   fl;
    logic [15:0]  left, left_blk, off, blen, rel, lenoff, hend;
    logic [7:0]   nib;
    logic [127:0] hs;

    assign in_ready = ev_ready;
    assign take = in_valid && in_ready;
    assign ev_valid = take && emit;
    assign ev_data = ev;

    assign hend = cc_reg ? 16'd16 : 16'd4;
    assign left = total_reg - pos_reg;
    assign left_blk = total_reg - cur_start_reg;
    assign nib = data_byte & 8'hF0;
    assign rel = pos_reg - cur_start_reg;
    assign lenoff = cur_v6_reg ? 16'd4 : 16'd2;
    assign blen = {len_hi_reg, data_byte};
    // block offset sits in header bytes 2 and 3
    assign off = cc_reg ? hdr_reg[111:96] : hdr_reg[15:0];
    assign fl = data_byte;

    // next-state and event selection
    always_comb begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        total_next = total_reg;
        hdr_next = hdr_reg;
        cc_next = cc_reg;
        cur_start_next = cur_start_reg;
        cur_v6_next = cur_v6_reg;
        len_hi_next = len_hi_reg;
        skip_next = skip_reg;
        emit = 1'b0;
        ev = '0;
        ev.bstart = pos_reg;
        ev.blen = left;
        hs = {hdr_reg[119:0], data_byte};
        if (first_byte) begin
            total_next = payload_length;
            pos_next = 16'd1;
            hdr_next = {120'd0, data_byte};
            len_hi_next = '0;
            skip_next = '0;
            if (payload_length < 16'd4 || fl[7] || (fl[6] && payload_length < 16'd16)) begin
                phase_next = PH_IDLE;
                cc_next = 1'b0;
                emit = 1'b1;
                ev.kind = EV_REJECT;
                ev.bstart = '0;
                ev.blen = payload_length;
            end else begin
                cc_next = fl[6];
                phase_next = PH_HEADER;
            end
        end else if (phase_reg != PH_IDLE && pos_reg < total_reg) begin
            case (phase_reg)
                PH_HEADER: begin
                    hdr_next = hs;
                    if (pos_reg + 16'd1 >= hend) begin
                        emit = 1'b1;
                        ev.kind = EV_HEADER;
                        ev.bstart = '0;
                        ev.blen = hend;
                        ev.cc_present = cc_reg;
                        if (cc_reg) begin
                            ev.offset = hs[111:96];
                            ev.rtt = hs[95:80];
                            ev.delay = hs[79:64];
                            ev.loss_rate = hs[63:32];
                            ev.rx_seq = hs[31:0];
                        end else begin
                            ev.offset = hs[15:0];
                        end
                        phase_next = PH_AFTER_HDR;
                    end
                end
                PH_AFTER_HDR, PH_BLOCK_FIRST: begin
                    if (phase_reg == PH_AFTER_HDR && off != '0) begin
                        emit = 1'b1;
                        ev.kind = EV_CONT;
                        ev.blen = (off < left) ? off : left;
                        skip_next = off - 16'd1;
                        phase_next = (skip_next == '0) ? PH_BLOCK_FIRST : PH_SKIP;
                    end else if (nib == 8'h40 || nib == 8'h60) begin
                        if (left < ((nib == 8'h40) ? 16'd4 : 16'd6)) begin
                            emit = 1'b1;
                            ev.kind = (nib == 8'h40) ? EV_IPV4_FRAG : EV_IPV6_FRAG;
                            phase_next = PH_IDLE;
                        end else begin
                            cur_v6_next = (nib == 8'h60);
                            cur_start_next = pos_reg;
                            len_hi_next = '0;
                            phase_next = PH_BLOCK_HEAD;
                        end
                    end else begin
                        emit = 1'b1;
                        phase_next = PH_IDLE;
                        if (nib == 8'h00) begin
                            ev.kind = EV_PAD;
                            ev.all_pad = (pos_reg == hend);
                        end else begin
                            ev.kind = EV_UNKNOWN;
                        end
                    end
                end
                PH_BLOCK_HEAD: begin
                    if (rel == lenoff) begin
                        len_hi_next = data_byte;
                    end else if (rel == lenoff + 16'd1) begin
                        emit = 1'b1;
                        ev.bstart = cur_start_reg;
                        ev.blen = left_blk;
                        if (blen > left_blk) begin
                            ev.kind = cur_v6_reg ? EV_IPV6_FRAG : EV_IPV4_FRAG;
                            phase_next = PH_IDLE;
                        end else if (blen < lenoff + 16'd2) begin
                            ev.kind = EV_UNKNOWN;
                            phase_next = PH_IDLE;
                        end else begin
                            ev.kind = cur_v6_reg ? EV_IPV6 : EV_IPV4;
                            ev.blen = blen;
                            skip_next = blen - (lenoff + 16'd2);
                            phase_next = (skip_next == '0) ? PH_BLOCK_FIRST : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_reg - 16'd1;
                    if (skip_next == '0) begin
                        phase_next = PH_BLOCK_FIRST;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
            pos_next = pos_reg + 16'd1;
            if ({1'b0, pos_reg} + 17'd1 >= {1'b0, total_reg}) begin
                phase_next = PH_IDLE;
            end
        end
    end

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg <= '0;
            total_reg <= '0;
            cc_reg <= 1'b0;
            skip_reg <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            total_reg <= total_next;
            cc_reg <= cc_next;
            skip_reg <= skip_next;
        end
    end

    // payload state
    always_ff @(posedge aclk) begin
        if (take) begin
            hdr_reg <= hdr_next;
            cur_start_reg <= cur_start_next;
            cur_v6_reg <= cur_v6_next;
            len_hi_reg <= len_hi_next;
        end
    end

    `IPBP_ASSERT(a_skip_nonzero, aclk, aresetn, (phase_reg == PH_SKIP) |-> (skip_reg != '0), "skip phase with zero count")
    `IPBP_ASSERT(a_reject_first, aclk, aresetn, (ev_valid && ev_data.kind == EV_REJECT) |-> first_byte, "reject not on first byte")
    `IPBP_ASSERT(a_ready_follow, aclk, aresetn, in_ready == ev_ready, "input ready not tied to queue")

endmodule

// ===== rtl/ipbp_queue.sv =====
// two-entry event queue between parser and output stage
// depends on ipbp_pkg and iptfs_payload_block_parser_defines.svh
module ipbp_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  ipbp_pkg::ev_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output ipbp_pkg::ev_t rd_data
);
    import ipbp_pkg::*;
`include "iptfs_payload_block_parser_defines.svh"

    ev_t        mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    `IPBP_ASSERT(a_cnt_range, aclk, aresetn, cnt_reg != 2'd3, "queue count out of range")
    `IPBP_ASSERT(a_ptr_cnt, aclk, aresetn, (cnt_reg == 2'd1) |-> (wp_reg != rp_reg), "pointer mismatch")
    `IPBP_ASSERT(a_full_no_wr, aclk, aresetn, (cnt_reg == 2'd2) |-> !wr, "write into full queue")

endmodule

// ===== rtl/iptfs_payload_block_parser.sv =====
// top level: iptfs payload data block parser
// depends on ipbp_pkg, ipbp_front, ipbp_queue
//
//  channel | dir | tdata                                | tuser
//  s_      | in  | data_byte[7:0], payload_length[23:8] | first_byte
//  m_      | out | event fields, see port comment       | event_kind[3:0]
//
// one byte is taken per cycle while the queue has room; at most one event per byte
// events are registered in a two-entry queue before they reach the output
// input stalls while the queue holds two events, even for bytes that make no event
// reset is synchronous on aresetn and clears parser phase and queue
module iptfs_payload_block_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // data_byte[7:0], payload_length[23:8]
    input  logic         s_tuser,   // first_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // block_start[15:0], block_length[31:16], cc_present[32], offset_field[48:33],
    // rtt_field[64:49], delay_field[80:65], loss_rate_field[112:81],
    // rx_seq_field[144:113], all_pad[145], zero fill
    output logic [151:0] m_tdata,
    output logic [3:0]   m_tuser    // event_kind[3:0]
);
    import ipbp_pkg::*;

    logic ev_valid, ev_ready;
    ev_t  ev_data, q_data;

    ipbp_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .data_byte(s_tdata[7:0]), .first_byte(s_tuser),
        .payload_length(s_tdata[8 +: LenW]),
        .ev_valid(ev_valid), .ev_data(ev_data), .ev_ready(ev_ready)
    );

    ipbp_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(ev_valid), .wr_ready(ev_ready), .wr_data(ev_data),
        .rd_valid(m_tvalid), .rd_ready(m_tready), .rd_data(q_data)
    );

    assign m_tdata = {6'b000000, q_data[EvW-1:4]};
    assign m_tuser = q_data.kind;

endmodule
